@@ hdl/ale_pkg.sv @@
// ----------------------------------------------------------------------------
// ale_pkg: shared types and constants for the associated Legendre evaluator
// Fixed-point formats, saturation limit and the operation codes of the
// shared arithmetic unit.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int unsigned ValW = 64;
  localparam int unsigned XW   = 32;
  localparam int unsigned NW   = 16;

  localparam logic [ValW-1:0] SatMag  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValW-1:0] FixOne  = 64'h0000_0100_0000_0000;
  localparam logic signed [XW-1:0] XOne = 32'sh4000_0000;

  typedef enum logic [2:0] {
    OP_MULN,
    OP_MULX,
    OP_SUB,
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic            start;
    alu_op_t         op;
    logic [ValW-1:0] a;
    logic [ValW-1:0] b;
    logic [NW-1:0]   n;
  } alu_req_t;

endpackage

@@ hdl/ale_alu.sv @@
// ----------------------------------------------------------------------------
// ale_alu: shared multi-cycle arithmetic unit
// Sign-magnitude multiply by integer, multiply by Q1.30 with rounding,
// saturating subtract, rounded division by integer (one bit per cycle) and
// integer square root (two bits per cycle step).
// ----------------------------------------------------------------------------
module ale_alu (
  input  logic                  clk,
  input  logic                  rst,
  input  ale_pkg::alu_req_t     req,
  output logic                  done,
  output logic [63:0]           result
);
  import ale_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_MULX2, S_DIV, S_SQRT, S_FIN} st_t;

  st_t             state;
  alu_op_t         op;
  logic            neg;
  logic [63:0]     ma;
  logic [63:0]     mb;
  logic [NW-1:0]   dn;
  logic [127:0]    prod;
  logic [63:0]     quo;
  logic [63:0]     rem;
  logic [6:0]      cnt;
  logic [63:0]     sres;
  logic [63:0]     sbit;

  logic [63:0]     a_mag;
  logic [63:0]     b_mag;
  logic [64:0]     rem_sh;
  logic [64:0]     rem_try;
  logic [63:0]     sum_b;
  logic [64:0]     sub_r;
  logic [65:0]     xr;
  logic [63:0]     sat_v;

  assign a_mag = req.a[63] ? (64'd0 - req.a) : req.a;
  assign b_mag = req.b[63] ? (64'd0 - req.b) : req.b;
  assign rem_sh  = {rem, quo[63]};
  assign rem_try = rem_sh - {49'd0, dn};
  assign sum_b   = sres + sbit;
  assign xr      = prod[95:30] + {65'd0, prod[29]};

  // saturating subtract on signed operands
  always_comb begin
    sub_r = {ma[63], ma} - {mb[63], mb};
    if ($signed(sub_r) > $signed({1'b0, SatMag})) begin
      sat_v = SatMag;
    end else if ($signed(sub_r) < -$signed({1'b0, SatMag})) begin
      sat_v = 64'd0 - SatMag;
    end else begin
      sat_v = sub_r[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            op  <= req.op;
            dn  <= req.n;
            cnt <= 7'd0;
            unique case (req.op)
              OP_MULN: begin
                neg <= req.a[63];
                ma  <= a_mag;
                mb  <= 64'(req.n);
                state <= S_MUL;
              end
              OP_MULX: begin
                neg <= req.a[63] ^ req.b[63];
                ma  <= a_mag;
                mb  <= b_mag;
                state <= S_MUL;
              end
              OP_SUB: begin
                ma <= req.a;
                mb <= req.b;
                state <= S_FIN;
              end
              OP_DIV: begin
                neg <= req.a[63];
                quo <= a_mag;
                rem <= 64'd0;
                state <= (req.n == '0) ? S_FIN : S_DIV;
                ma  <= req.a;
              end
              OP_SQRT: begin
                quo  <= req.a;
                sres <= 64'd0;
                sbit <= 64'h4000_0000_0000_0000;
                state <= S_SQRT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MUL: begin
          // low half of the magnitude first, then the high half
          prod  <= {96'd0, ma[31:0]} * {96'd0, mb[31:0]};
          state <= S_MULX2;
        end
        S_MULX2: begin
          prod  <= prod + (({96'd0, ma[63:32]} * {96'd0, mb[31:0]}) << 32);
          state <= S_FIN;
        end
        S_DIV: begin
          if (!rem_try[64]) begin
            rem <= rem_try[63:0];
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            quo <= {quo[62:0], 1'b0};
          end
          cnt <= cnt + 7'd1;
          if (cnt == 7'd63) state <= S_FIN;
        end
        S_SQRT: begin
          if (sbit != 64'd0) begin
            if (quo >= sum_b) begin
              quo  <= quo - sum_b;
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
          unique case (op)
            OP_MULN, OP_MULX: begin
              logic [127:0] m;
              m = (op == OP_MULX) ? {62'd0, xr} : prod;
              if (m > {64'd0, SatMag}) begin
                result <= neg ? (64'd0 - SatMag) : SatMag;
              end else begin
                result <= neg ? (64'd0 - m[63:0]) : m[63:0];
              end
            end
            OP_SUB:  result <= sat_v;
            OP_DIV: begin
              if (dn == '0) begin
                result <= ma;
              end else begin
                logic [63:0] q;
                q = quo + {63'd0, ({rem, 1'b0} >= {49'd0, dn})};
                if (q > SatMag) q = SatMag;
                result <= neg ? (64'd0 - q) : q;
              end
            end
            OP_SQRT: result <= sres;
            default: result <= 64'd0;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/assoc_legendre_eval_top.sv @@
// ----------------------------------------------------------------------------
// assoc_legendre_eval_top: associated Legendre evaluator, P_lm(x)
// A zero result goes straight to the output; else the seed P_mm is built first,
// followed by the upward recurrence when l > |m| and one division per
// negative-order step; the divider takes 64 steps and the square root 32.
// One item at a time: ready is low from accept until the result beat is taken.
// Synchronous reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module assoc_legendre_eval_top #(
  parameter int unsigned MAX_DEGREE = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // degree[3:0], order[8:4], cos_theta[40:9], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // legendre_value[63:0]
);
  import ale_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_XSQ, S_SQ, S_SEEDN, S_SEEDX, S_P1N, S_P1X,
    S_T1N, S_T1X, S_T2N, S_SUB, S_DIVR, S_NEG, S_NDIV, S_OUT
  } st_t;

  st_t              state;
  alu_req_t         req;
  logic             done;
  logic [63:0]      res;
  logic [3:0]       deg;
  logic [3:0]       am;
  logic             mneg;
  logic [63:0]      x;
  logic [63:0]      s;
  logic [63:0]      pm;
  logic [63:0]      pprev;
  logic [63:0]      t1;
  logic [NW-1:0]    fact;
  logic [4:0]       i;
  logic [4:0]       k;
  logic             busy;

  logic [3:0]             in_deg;
  logic signed [4:0]      in_ord;
  logic signed [XW-1:0]   in_x;
  logic signed [XW-1:0]   xc;
  logic [4:0]             in_am;
  logic [63:0]            xm;
  logic [XW-1:0]          xabs;

  assign in_deg = s_tdata[3:0];
  assign in_ord = s_tdata[8:4];
  assign in_x   = s_tdata[40:9];
  assign xc = (in_x > XOne) ? XOne : ((in_x < -XOne) ? -XOne : in_x);
  assign in_am = in_ord[4] ? (5'd0 - in_ord) : in_ord;
  assign xm = {{32{xc[31]}}, xc};
  assign xabs = xc[XW-1] ? (32'd0 - xc) : xc;

  ale_alu u_alu (.clk(clk), .rst(rst), .req(req), .done(done), .result(res));

  assign s_tready = (state == S_IDLE);
  assign busy = req.start;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      req      <= '0;
    end else begin
      req.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            deg  <= in_deg;
            am   <= in_am[3:0];
            mneg <= in_ord[4];
            x    <= xm;
            if ({1'b0, in_deg} > 5'(MAX_DEGREE) || in_am > {1'b0, in_deg}) begin
              m_tdata  <= 64'd0;
              m_tvalid <= 1'b1;
              state    <= S_OUT;
            end else begin
              // x^2 on the shared unit: (|x| << 30) * |x| >> 30
              req <= '{1'b1, OP_MULX, {2'd0, xabs, 30'd0}, {32'd0, xabs}, '0};
              pm    <= FixOne;
              fact  <= 16'd1;
              k     <= 5'd0;
              state <= S_XSQ;
            end
          end
        end
        S_XSQ: if (done && !busy) begin
          // s^2 = 2^60 - x^2
          req   <= '{1'b1, OP_SQRT, 64'h1000_0000_0000_0000 - res, 64'd0, '0};
          state <= S_SQ;
        end
        S_SQ: if (done && !busy) begin
          s <= res;
          if (k[3:0] != am) begin
            req   <= '{1'b1, OP_MULN, FixOne, 64'd0, fact};
            state <= S_SEEDN;
          end else if (am == deg) begin
            t1    <= FixOne;
            state <= S_NEG;
            k     <= 5'd1;
          end else begin
            req   <= '{1'b1, OP_MULN, FixOne, 64'd0, NW'({am, 1'b1})};
            state <= S_P1N;
          end
        end
        S_SEEDN: if (done && !busy) begin
          req   <= '{1'b1, OP_MULX, res, s, '0};
          state <= S_SEEDX;
        end
        S_SEEDX: if (done && !busy) begin
          pm   <= res;
          fact <= fact + 16'd2;
          k    <= k + 5'd1;
          if (k[3:0] + 4'd1 != am) begin
            req   <= '{1'b1, OP_MULN, res, 64'd0, fact + 16'd2};
            state <= S_SEEDN;
          end else if (am == deg) begin
            t1    <= res;
            k     <= 5'd1;
            state <= S_NEG;
          end else begin
            req   <= '{1'b1, OP_MULN, res, 64'd0, NW'({am, 1'b1})};
            state <= S_P1N;
          end
        end
        S_P1N: if (done && !busy) begin
          req   <= '{1'b1, OP_MULX, res, x, '0};
          state <= S_P1X;
        end
        S_P1X: if (done && !busy) begin
          // pprev takes P_(i-2), t1 takes P_(i-1)
          pprev <= pm;
          t1    <= res;
          i     <= {1'b0, am} + 5'd2;
          if ({1'b0, am} + 5'd2 > {1'b0, deg}) begin
            k     <= 5'd1;
            state <= S_NEG;
          end else begin
            req   <= '{1'b1, OP_MULN, res, 64'd0,
                       NW'({1'b0, am, 1'b0} + 6'd3)};
            pm    <= res;
            state <= S_T1N;
          end
        end
        S_T1N: if (done && !busy) begin
          req   <= '{1'b1, OP_MULX, res, x, '0};
          state <= S_T1X;
        end
        S_T1X: if (done && !busy) begin
          t1    <= res;
          req   <= '{1'b1, OP_MULN, pprev, 64'd0, NW'(i + {1'b0, am} - 5'd1)};
          state <= S_T2N;
        end
        S_T2N: if (done && !busy) begin
          req   <= '{1'b1, OP_SUB, t1, res, '0};
          state <= S_SUB;
        end
        S_SUB: if (done && !busy) begin
          req   <= '{1'b1, OP_DIV, res, 64'd0, NW'(i - {1'b0, am})};
          state <= S_DIVR;
        end
        S_DIVR: if (done && !busy) begin
          t1 <= res;
          if (i == {1'b0, deg}) begin
            k     <= 5'd1;
            state <= S_NEG;
          end else begin
            // shift the window: P_(i-1) becomes pprev
            pprev <= pm;
            pm    <= res;
            i     <= i + 5'd1;
            req   <= '{1'b1, OP_MULN, res, 64'd0, NW'({i + 5'd1, 1'b0} - 6'd1)};
            state <= S_T1N;
          end
        end
        S_NEG: begin
          if (!mneg || k > {1'b0, am}) begin
            m_tdata  <= (mneg && am[0]) ? (64'd0 - t1) : t1;
            m_tvalid <= 1'b1;
            state    <= S_OUT;
          end else begin
            req   <= '{1'b1, OP_DIV, t1, 64'd0,
                       NW'(10'({1'b0, deg} - k + 5'd1) * 10'({1'b0, deg} + k))};
            state <= S_NDIV;
          end
        end
        S_NDIV: if (done && !busy) begin
          t1    <= res;
          k     <= k + 5'd1;
          state <= S_NEG;
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
